/* src/sgr_pkg.sv */
// Shared types, constants and font tables for the scaled glyph rasterizer.
package sgr_pkg;

	localparam int CW          = 14;  // signed width of working pixel coordinates
	localparam int GLYPH_ROWS  = 7;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPHS      = 36;
	localparam int LETTERS     = 26;
	localparam logic [3:0] SCALE_MAX = 4'd8;
	localparam logic signed [12:0] PEN_MAX = 13'sd2047;
	localparam logic [2:0] LAST_ROW = 3'd6;
	localparam logic [2:0] LAST_COL = 3'd4;

	typedef struct packed {
		logic [7:0]         char_code;
		logic               first_of_string;
		logic signed [11:0] origin_x;
		logic signed [11:0] origin_y;
		logic [3:0]         scale;
		logic [15:0]        color;
	} item_t;

	typedef struct packed {
		logic [15:0] start_address;
		logic [3:0]  block_width;
		logic [3:0]  block_height;
		logic [15:0] pixel_data;
		logic        last;
	} blk_t;

	// One glyph cell as handed from the sequencer to the clip unit.
	typedef struct packed {
		logic                 vld;
		logic                 lit;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
	} cell_t;

	typedef struct packed {
		logic       found;
		logic [5:0] idx;
	} glyph_sel_t;

	// Low five bits per row, leftmost column in bit 4.
	localparam logic [4:0] GLYPH_ROM [0:GLYPHS-1][0:GLYPH_ROWS-1] = '{
		'{5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17},
		'{5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30},
		'{5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14},
		'{5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30},
		'{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31},
		'{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16},
		'{5'd14,5'd17,5'd16,5'd23,5'd17,5'd17,5'd15},
		'{5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17},
		'{5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd31},
		'{5'd7,5'd2,5'd2,5'd2,5'd18,5'd18,5'd12},
		'{5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17},
		'{5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31},
		'{5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17},
		'{5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17},
		'{5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14},
		'{5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16},
		'{5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13},
		'{5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17},
		'{5'd15,5'd16,5'd16,5'd14,5'd1,5'd1,5'd30},
		'{5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4},
		'{5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14},
		'{5'd17,5'd17,5'd17,5'd17,5'd17,5'd10,5'd4},
		'{5'd17,5'd17,5'd17,5'd21,5'd21,5'd21,5'd10},
		'{5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17},
		'{5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4},
		'{5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31},
		'{5'd14,5'd17,5'd19,5'd21,5'd25,5'd17,5'd14},
		'{5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14},
		'{5'd14,5'd17,5'd1,5'd2,5'd4,5'd8,5'd31},
		'{5'd30,5'd1,5'd1,5'd14,5'd1,5'd1,5'd30},
		'{5'd2,5'd6,5'd10,5'd18,5'd31,5'd2,5'd2},
		'{5'd31,5'd16,5'd16,5'd30,5'd1,5'd1,5'd30},
		'{5'd14,5'd16,5'd16,5'd30,5'd17,5'd17,5'd14},
		'{5'd31,5'd1,5'd2,5'd4,5'd8,5'd8,5'd8},
		'{5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14},
		'{5'd14,5'd17,5'd17,5'd15,5'd1,5'd1,5'd14}
	};

	// Letters of either case map to 0..25, digits to 26..35.
	function automatic glyph_sel_t char_to_glyph(input logic [7:0] ch);
		glyph_sel_t r;
		r.found = 1'b0;
		r.idx   = '0;
		if (ch >= 8'h61 && ch <= 8'h7a) begin
			r.found = 1'b1;
			r.idx   = 6'(ch - 8'h61);
		end else if (ch >= 8'h41 && ch <= 8'h5a) begin
			r.found = 1'b1;
			r.idx   = 6'(ch - 8'h41);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r.found = 1'b1;
			r.idx   = 6'(ch - 8'h30) + 6'(LETTERS);
		end
		return r;
	endfunction

endpackage

/* src/scaled_glyph_rasterizer.sv */
// Top level: character sequencer and pen state around the clip unit and emitter.
//
// One character is taken, then its 35 glyph cells are walked one per cycle, while the
// output is not stalled, through a single clip unit, lit and visible cells leaving as fill
// blocks in row-then-column order. A letter or digit occupies the block for the 35 cell
// steps, one step to drain the clip register and one to mark the final block; any other
// character passes only through the marking step. No new character is taken until the last
// one is done. The walk halts while a finished block waits under output stall. The cell
// walk through the shared clip unit sets the rate.
module scaled_glyph_rasterizer import sgr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 172,
	parameter int SCREEN_HEIGHT = 320
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  blk_valid,
	input  logic  blk_stall,
	output blk_t  blk
);

	localparam int XCW = $clog2(SCREEN_WIDTH);
	localparam int YCW = $clog2(SCREEN_HEIGHT);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t               state_q;
	logic signed [11:0]   pen_q;
	logic signed [CW-1:0] xbase_q, xcur_q, ycur_q;
	logic [2:0]           row_q, col_q;
	logic [5:0]           glyph_q;
	logic [3:0]           scale_q;
	logic [15:0]          pixel_q;

	logic                 accept, adv, flush, vld_s1;
	logic [XCW-1:0]       x0c_s1;
	logic [YCW-1:0]       y0c_s1;
	logic [3:0]           bw_s1, bh_s1;
	logic [3:0]           scale_in;
	logic signed [11:0]   pen_start;
	logic signed [12:0]   pen_sum;
	logic signed [CW-1:0] sc;
	glyph_sel_t           gsel;
	logic [4:0]           row_bits;
	cell_t                dot;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign flush      = (state_q == ST_FIN);

	always_comb begin
		if (item.scale == 4'd0) begin
			scale_in = 4'd1;
		end else if (item.scale > SCALE_MAX) begin
			scale_in = SCALE_MAX;
		end else begin
			scale_in = item.scale;
		end
		pen_start = item.first_of_string ? item.origin_x : pen_q;
		pen_sum   = 13'(pen_start) + $signed({3'b000, scale_in, 2'b00})
		          + $signed({4'b0000, scale_in, 1'b0});
		gsel      = char_to_glyph(item.char_code);
		sc        = $signed({{(CW-4){1'b0}}, scale_q});
		row_bits  = GLYPH_ROM[glyph_q][row_q];
		dot.vld   = (state_q == ST_SCAN);
		dot.lit   = row_bits[LAST_COL - col_q];
		dot.x0    = xcur_q;
		dot.y0    = ycur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pen_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pen_q   <= (pen_sum > PEN_MAX) ? 12'sd2047 : pen_sum[11:0];
						row_q   <= '0;
						col_q   <= '0;
						state_q <= gsel.found ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						if (col_q == LAST_COL) begin
							col_q <= '0;
							row_q <= row_q + 3'd1;
							if (row_q == LAST_ROW) begin
								state_q <= ST_FLUSH;
							end
						end else begin
							col_q <= col_q + 3'd1;
						end
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Cell origin advances by one scale step per column, resets per row.
	always_ff @(posedge clk) begin
		if (accept) begin
			xbase_q <= CW'(pen_start);
			xcur_q  <= CW'(pen_start);
			ycur_q  <= CW'(item.origin_y);
			glyph_q <= gsel.idx;
			scale_q <= scale_in;
			pixel_q <= {item.color[7:0], item.color[15:8]};
		end else if (state_q == ST_SCAN && adv) begin
			if (col_q == LAST_COL) begin
				xcur_q <= xbase_q;
				ycur_q <= ycur_q + sc;
			end else begin
				xcur_q <= xcur_q + sc;
			end
		end
	end

	sgr_clip #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_clip (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.dot   (dot),
		.scale (scale_q),
		.vld_s1(vld_s1),
		.x0c_s1(x0c_s1),
		.y0c_s1(y0c_s1),
		.bw_s1 (bw_s1),
		.bh_s1 (bh_s1)
	);

	sgr_emit #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.x0c_s1   (x0c_s1),
		.y0c_s1   (y0c_s1),
		.bw_s1    (bw_s1),
		.bh_s1    (bh_s1),
		.flush    (flush),
		.pixel    (pixel_q),
		.adv      (adv),
		.blk_valid(blk_valid),
		.blk_stall(blk_stall),
		.blk      (blk)
	);

endmodule

/* src/sgr_clip.sv */
// Shared clip unit: clips one scaled glyph cell against the screen, registered.
module sgr_clip import sgr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 172,
	parameter int SCREEN_HEIGHT = 320,
	localparam int XCW = $clog2(SCREEN_WIDTH),
	localparam int YCW = $clog2(SCREEN_HEIGHT)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  cell_t          dot,
	input  logic [3:0]     scale,
	output logic           vld_s1,
	output logic [XCW-1:0] x0c_s1,
	output logic [YCW-1:0] y0c_s1,
	output logic [3:0]     bw_s1,
	output logic [3:0]     bh_s1
);

	localparam logic signed [CW-1:0] WS = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] HS = CW'(SCREEN_HEIGHT);

	logic signed [CW-1:0] sc, x1, y1, x0c, y0c, x1c, y1c, dx, dy;
	logic vis;

	always_comb begin
		sc  = $signed({{(CW-4){1'b0}}, scale});
		x1  = dot.x0 + sc;
		y1  = dot.y0 + sc;
		x0c = dot.x0[CW-1] ? '0 : dot.x0;
		y0c = dot.y0[CW-1] ? '0 : dot.y0;
		x1c = (x1 > WS) ? WS : x1;
		y1c = (y1 > HS) ? HS : y1;
		dx  = x1c - x0c;
		dy  = y1c - y0c;
		vis = (dx > 0) && (dy > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= dot.vld & dot.lit & vis;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0c_s1 <= x0c[XCW-1:0];
			y0c_s1 <= y0c[YCW-1:0];
			bw_s1  <= dx[3:0];
			bh_s1  <= dy[3:0];
		end
	end

endmodule

/* src/sgr_emit.sv */
// Address multiply, one-deep hold for the last-block mark, and output register.
module sgr_emit import sgr_pkg::*; #(
	parameter int SCREEN_WIDTH  = 172,
	parameter int SCREEN_HEIGHT = 320,
	localparam int XCW = $clog2(SCREEN_WIDTH),
	localparam int YCW = $clog2(SCREEN_HEIGHT),
	localparam int AW  = XCW + YCW + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_s1,
	input  logic [XCW-1:0] x0c_s1,
	input  logic [YCW-1:0] y0c_s1,
	input  logic [3:0]     bw_s1,
	input  logic [3:0]     bh_s1,
	input  logic           flush,
	input  logic [15:0]    pixel,
	output logic           adv,
	output logic           blk_valid,
	input  logic           blk_stall,
	output blk_t           blk
);

	logic [AW-1:0] addr;
	logic          pend_vld_q;
	blk_t          pend_q;
	blk_t          out_d;

	assign addr = AW'(y0c_s1) * AW'(SCREEN_WIDTH) + AW'(x0c_s1);
	// Move only when the output slot is empty or being taken.
	assign adv  = !blk_valid || !blk_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			blk_valid  <= 1'b0;
		end else if (adv) begin
			if (vld_s1) begin
				blk_valid  <= pend_vld_q;
				pend_vld_q <= 1'b1;
			end else if (flush) begin
				blk_valid  <= pend_vld_q;
				pend_vld_q <= 1'b0;
			end else begin
				blk_valid  <= 1'b0;
			end
		end
	end

	// Mark the held block as last when no further block follows it.
	always_comb begin
		out_d      = pend_q;
		out_d.last = !vld_s1;
	end

	// Hold each block until the next one shows it was not the last.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (vld_s1 || flush) begin
				blk <= out_d;
			end
			if (vld_s1) begin
				pend_q.start_address <= 16'(addr);
				pend_q.block_width   <= bw_s1;
				pend_q.block_height  <= bh_s1;
				pend_q.pixel_data    <= pixel;
				pend_q.last          <= 1'b0;
			end
		end
	end

endmodule

/* dv/scaled_glyph_rasterizer_test.sv */
// Self-checking testbench for the scaled glyph rasterizer: directed and random characters.
module scaled_glyph_rasterizer_test;
	import sgr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN_W     = 172;
	localparam int SCREEN_H     = 320;
	localparam int FONT_LETTERS = 26;
	localparam int DOT_COLS     = 5;
	localparam int DOT_ROWS     = 7;
	localparam int PEN_STEP     = 6;
	localparam int PEN_LIMIT    = 2047;
	localparam int MAX_SCALE    = 8;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE_CYCLES = 64;
	localparam int SHOWN_ERRORS = 10;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	item_t char_item = '0;
	logic  blk_valid;
	logic  blk_stall = 1'b0;
	blk_t  blk;

	int          pen_col;
	blk_t        pending_blocks[$];
	int          mismatches;
	int          chars_sent;
	int          blocks_checked;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned hold_requests;
	int unsigned holds_served;
	int unsigned hold_left;

	scaled_glyph_rasterizer #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (char_item),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// 5x7 font, rows top to bottom, leftmost dot in the high bit of each row.
	function automatic logic [34:0] glyph_dots(input int idx);
		case (idx)
			0:  return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
			1:  return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
			2:  return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
			3:  return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
			4:  return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
			5:  return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
			6:  return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
			7:  return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
			8:  return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31};
			9:  return {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12};
			10: return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
			11: return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
			12: return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
			13: return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
			14: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
			15: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
			16: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
			17: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
			18: return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
			19: return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
			20: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
			21: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
			22: return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
			23: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
			24: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
			25: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
			26: return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
			27: return {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
			28: return {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
			29: return {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
			30: return {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
			31: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
			32: return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
			33: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
			34: return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
			default: return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
		endcase
	endfunction

	function automatic int glyph_index(input logic [7:0] ch);
		if (ch >= 8'h61 && ch <= 8'h7a)
			return int'(ch) - 'h61;
		if (ch >= 8'h41 && ch <= 8'h5a)
			return int'(ch) - 'h41;
		if (ch >= 8'h30 && ch <= 8'h39)
			return int'(ch) - 'h30 + FONT_LETTERS;
		return -1;
	endfunction

	// Work out the fill blocks of one character and advance the pen.
	function automatic void rasterize_char(input item_t it);
		int          sc;
		int          gidx;
		int          x0, y0, x1, y1;
		int          oy;
		logic [34:0] dots;
		blk_t        fill;
		blk_t        char_blocks[$];

		sc = int'(it.scale);
		if (sc < 1)
			sc = 1;
		if (sc > MAX_SCALE)
			sc = MAX_SCALE;
		if (it.first_of_string)
			pen_col = int'(it.origin_x);
		oy = int'(it.origin_y);
		gidx = glyph_index(it.char_code);
		if (gidx >= 0) begin
			dots = glyph_dots(gidx);
			for (int r = 0; r < DOT_ROWS; r++) begin
				for (int c = 0; c < DOT_COLS; c++) begin
					if (dots[34 - (r * DOT_COLS + c)]) begin
						x0 = pen_col + c * sc;
						y0 = oy + r * sc;
						x1 = x0 + sc;
						y1 = y0 + sc;
						if (x0 < 0)
							x0 = 0;
						if (y0 < 0)
							y0 = 0;
						if (x1 > SCREEN_W)
							x1 = SCREEN_W;
						if (y1 > SCREEN_H)
							y1 = SCREEN_H;
						// drop cells that land wholly off screen
						if (x1 > x0 && y1 > y0) begin
							fill.start_address = 16'(y0 * SCREEN_W + x0);
							fill.block_width   = 4'(x1 - x0);
							fill.block_height  = 4'(y1 - y0);
							fill.pixel_data    = {it.color[7:0], it.color[15:8]};
							fill.last          = 1'b0;
							char_blocks.push_back(fill);
						end
					end
				end
			end
			if (char_blocks.size() != 0)
				char_blocks[$].last = 1'b1;
			foreach (char_blocks[i])
				pending_blocks.push_back(char_blocks[i]);
		end
		pen_col += PEN_STEP * sc;
		if (pen_col > PEN_LIMIT)
			pen_col = PEN_LIMIT;
	endfunction

	function automatic item_t make_char(input logic [7:0] ch, input logic first, input int ox,
			input int oy, input int sc, input logic [15:0] col);
		item_t it;
		it.char_code       = ch;
		it.first_of_string = first;
		it.origin_x        = 12'(ox);
		it.origin_y        = 12'(oy);
		it.scale           = 4'(sc);
		it.color           = col;
		return it;
	endfunction

	// Mostly letters and digits, mostly near the screen; otherwise any byte, anywhere.
	function automatic item_t random_char();
		item_t it;
		int    pick;
		pick = $urandom_range(99);
		if (pick < 45)
			it.char_code = 8'h41 + 8'($urandom_range(25));
		else if (pick < 75)
			it.char_code = 8'h61 + 8'($urandom_range(25));
		else if (pick < 88)
			it.char_code = 8'h30 + 8'($urandom_range(9));
		else
			it.char_code = 8'($urandom_range(255));
		it.first_of_string = ($urandom_range(99) < 35);
		if ($urandom_range(9) == 0) begin
			it.origin_x = 12'($urandom_range(4095));
			it.origin_y = 12'($urandom_range(4095));
		end else begin
			it.origin_x = 12'(int'($urandom_range(210)) - 30);
			it.origin_y = 12'(int'($urandom_range(360)) - 30);
		end
		if ($urandom_range(9) == 0)
			it.scale = 4'($urandom_range(15));
		else
			it.scale = 4'($urandom_range(MAX_SCALE, 1));
		it.color = 16'($urandom_range(65535));
		return it;
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic send_char(input item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_item  <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		rasterize_char(it);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(input int count, input int unsigned send_pct,
			input int unsigned rx_pct);
		send_idle_pct = send_pct;
		stall_pct     = rx_pct;
		repeat (count)
			send_char(random_char());
	endtask

	task automatic test_directed_glyphs();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_char(make_char(8'h41, 1'b1, 10, 10, 1, 16'h1234));      // A
		send_char(make_char(8'h7a, 1'b0, 0, 10, 2, 16'hffff));       // z, pen carries on
		send_char(make_char(8'h30, 1'b0, 0, 30, 3, 16'h0000));       // 0
		send_char(make_char(8'h39, 1'b0, 0, 30, 1, 16'habcd));       // 9
		send_char(make_char(8'h5a, 1'b1, 100, 200, 4, 16'h00ff));    // Z
		send_char(make_char(8'h20, 1'b0, 0, 200, 4, 16'hff00));      // space: pen only
		send_char(make_char(8'hff, 1'b1, 0, 0, 1, 16'h5a5a));
		send_char(make_char(8'h00, 1'b0, 0, 0, 1, 16'ha5a5));
		send_char(make_char(8'h40, 1'b1, 5, 5, 2, 16'h0f0f));        // just below A
		send_char(make_char(8'h7b, 1'b0, 5, 5, 2, 16'hf0f0));        // just above z
		send_char(make_char(8'h3a, 1'b0, 5, 5, 2, 16'h1111));        // just above 9
		send_char(make_char(8'h2f, 1'b0, 5, 5, 2, 16'h2222));        // just below 0
		send_char(make_char(8'h4d, 1'b1, 20, 20, 0, 16'h3333));      // scale zero acts as one
		send_char(make_char(8'h57, 1'b1, 40, 40, 15, 16'h4444));     // scale clamps to eight
		send_char(make_char(8'h42, 1'b1, -3, -5, 8, 16'h8001));      // clipped left and top
		send_char(make_char(8'h48, 1'b1, 170, 315, 8, 16'h7ffe));    // clipped right and bottom
		send_char(make_char(8'h38, 1'b1, 10, -2048, 8, 16'hc3c3));   // wholly above the screen
		send_char(make_char(8'h58, 1'b1, -20, 100, 4, 16'h3c3c));    // every cell lands left of the screen
		send_char(make_char(8'h51, 1'b1, 2040, 0, 8, 16'h0001));     // pen runs past the limit
		send_char(make_char(8'h52, 1'b0, 0, 0, 8, 16'h8000));        // pen stays saturated
		send_char(make_char(8'h4b, 1'b1, -2048, 2047, 1, 16'h7777)); // extreme origins
		send_char(make_char(8'h6d, 1'b1, 0, 0, 8, 16'h9999));        // lowercase at the corner
		send_char(make_char(8'h37, 1'b1, 2047, -1, 8, 16'heeee));
		wait_drained();
	endtask

	task automatic test_streaming();
		run_random(85, 0, 0);
	endtask

	task automatic test_sender_gaps();
		run_random(85, 86, 0);
	endtask

	task automatic test_receiver_stalls();
		run_random(85, 0, 86);
	endtask

	task automatic test_mixed_idling();
		run_random(85, 11, 11);
	endtask

	// Hold the output off long enough that the input stalls while items keep coming.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_requests++;
		for (int i = 0; i < 12; i++)
			send_char(make_char(8'h41 + 8'(i), 1'b1, 10 * i, 20, 8, 16'(i * 4099)));
		wait_drained();
	endtask

	task automatic test_pause_between_strings();
		for (int i = 0; i < 3; i++) begin
			run_random(8, 11, 11);
			wait_drained();
		end
	endtask

	function automatic void note_mismatch(input string what, input blk_t want, input blk_t got);
		mismatches++;
		if (mismatches <= SHOWN_ERRORS) begin
			$display("%s: expected addr=%0d w=%0d h=%0d data=%h last=%b,",
				what, want.start_address, want.block_width, want.block_height,
				want.pixel_data, want.last);
			$display("    got addr=%0d w=%0d h=%0d data=%h last=%b",
				got.start_address, got.block_width, got.block_height,
				got.pixel_data, got.last);
		end
	endfunction

	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left    = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			blk_stall <= 1'b1;
		end else begin
			blk_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		blk_t want;
		if (arst_n && blk_valid && !blk_stall) begin
			if (pending_blocks.size() == 0) begin
				note_mismatch("unexpected fill block", '0, blk);
			end else begin
				want = pending_blocks.pop_front();
				blocks_checked++;
				if (blk.start_address !== want.start_address
						|| blk.block_width !== want.block_width
						|| blk.block_height !== want.block_height
						|| blk.pixel_data !== want.pixel_data
						|| blk.last !== want.last)
					note_mismatch("fill block mismatch", want, blk);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		pen_col        = 0;
		mismatches     = 0;
		chars_sent     = 0;
		blocks_checked = 0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		hold_requests  = 0;
		holds_served   = 0;
		hold_left      = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_glyphs();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		test_output_backpressure();
		test_pause_between_strings();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += pending_blocks.size();

		$display("Sent %0d characters: letters, digits, other bytes, clipping, off-screen cells,",
			chars_sent);
		$display("scale limits and pen saturation; checked %0d fill blocks under gaps and stalls.",
			blocks_checked);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
